// ----- rtl/doa_pkg.sv -----
// ----------------------------------------------------------------------------
// doa_pkg
// Shared types, codes and helpers for the deflection output port allocator.
// ----------------------------------------------------------------------------
package doa_pkg;

    // Field and map widths
    localparam int PORT_W   = 3;
    localparam int DIR_W    = 3;
    localparam int MAP_W    = 15;
    localparam int STATUS_W = 2;
    localparam int PORT_SPACE = 1 << PORT_W;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_LOCAL = 3'd4;

    // Map reset: port i carries direction code i
    localparam logic [MAP_W-1:0] MAP_RESET = 15'd18056;

    // Word modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Configuration register indexes
    localparam logic REG_INPORT_MAP  = 1'b0;
    localparam logic REG_OUTPORT_MAP = 1'b1;

    // Grant status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_PREFERRED      = 2'd0,
        ST_MISROUTED      = 2'd1,
        ST_LOCAL_FALLBACK = 2'd2,
        ST_NO_PORT        = 2'd3
    } grant_status_t;

    // Direction code of a port; ports past the top of the map read as code zero
    function automatic logic [DIR_W-1:0] dir_of(
        input logic [MAP_W-1:0]  map,
        input logic [PORT_W-1:0] port
    );
        logic [DIR_W-1:0] d;
        d = 3'd0;
        case (port)
            3'd0:    d = map[2:0];
            3'd1:    d = map[5:3];
            3'd2:    d = map[8:6];
            3'd3:    d = map[11:9];
            3'd4:    d = map[14:12];
            default: d = 3'd0;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/deflection_outport_allocator_core.sv -----
// A request word is registered in the input stage on acceptance, and its grant is
// registered in the result stage once that stage is free. Throughput: one word per
// cycle unless the grant channel stalls; the tracker update and the next lookup
// meet in the single allocation stage. Ticks and out-of-range requests give
// no result. Reset clears the tracker and loads both direction maps.
// ----------------------------------------------------------------------------
// deflection_outport_allocator_core
// Output port allocator of a bufferless deflection router: grants the preferred
// port when free, else deflects to a free non-local port; else fallback or no port.
// ----------------------------------------------------------------------------
module deflection_outport_allocator_core #(
    parameter int PORTS = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,

    // Configuration write port
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [doa_pkg::MAP_W-1:0]   cfg_wdata,

    // Request channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        mode,
    input  logic [doa_pkg::PORT_W-1:0]  in_port,
    input  logic [doa_pkg::PORT_W-1:0]  preferred_port,

    // Grant channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [doa_pkg::PORT_W-1:0]  granted_port,
    output logic [doa_pkg::STATUS_W-1:0] grant_status
);
    import doa_pkg::*;

    localparam logic [PORT_W:0] PORTS_LIM = (PORT_W+1)'(PORTS);

    // Direction maps
    logic [MAP_W-1:0] inport_map_reg;
    logic [MAP_W-1:0] outport_map_reg;

    // Input stage
    logic              s1_valid_reg;
    logic              s1_mode_reg;
    logic [PORT_W-1:0] s1_in_port_reg;
    logic [PORT_W-1:0] s1_pref_reg;

    // Tracker
    logic [PORT_W-1:0] grant_port_reg [PORTS];
    logic [PORTS-1:0]  grant_valid_reg;

    // Result stage
    logic              out_valid_reg;
    logic [PORT_W-1:0] out_port_reg;
    grant_status_t     out_status_reg;

    // Allocation logic
    logic [DIR_W-1:0]      in_dir;
    logic [PORT_SPACE-1:0] taken;
    logic [PORT_SPACE-1:0] cand;
    logic [PORT_W-1:0]     first_diff;
    logic                  found_diff;
    logic [PORT_W-1:0]     last_any;
    logic                  found_any;
    logic                  in_range;
    logic                  produces;
    logic                  out_free;
    logic                  s1_adv;
    logic                  tracker_wr;
    logic [PORT_W-1:0]     grant_next;
    grant_status_t         status_next;

    // Mark output ports held by non-local inputs this cycle
    always_comb
    begin
        for (int o = 0; o < PORT_SPACE; o++)
        begin
            taken[o] = 1'b0;
            for (int i = 0; i < PORTS; i++)
            begin
                if (grant_valid_reg[i] && grant_port_reg[i] == PORT_W'(o) &&
                    dir_of(inport_map_reg, PORT_W'(i)) != DIR_LOCAL)
                begin
                    taken[o] = 1'b1;
                end
            end
        end
    end

    // Pick the grant for the word in the input stage
    always_comb
    begin
        in_dir = dir_of(inport_map_reg, s1_in_port_reg);

        for (int o = 0; o < PORT_SPACE; o++)
        begin
            cand[o] = (o < PORTS) && !taken[o] &&
                      dir_of(outport_map_reg, PORT_W'(o)) != DIR_LOCAL;
        end

        // Lowest free port facing another direction
        first_diff = '0;
        found_diff = 1'b0;
        for (int o = PORT_SPACE - 1; o >= 0; o--)
        begin
            if (cand[o] && dir_of(outport_map_reg, PORT_W'(o)) != in_dir)
            begin
                first_diff = PORT_W'(o);
                found_diff = 1'b1;
            end
        end

        // Highest free non-local port
        last_any  = '0;
        found_any = 1'b0;
        for (int o = 0; o < PORT_SPACE; o++)
        begin
            if (cand[o])
            begin
                last_any  = PORT_W'(o);
                found_any = 1'b1;
            end
        end

        if (!taken[s1_pref_reg])
        begin
            grant_next  = s1_pref_reg;
            status_next = ST_PREFERRED;
        end
        else if (found_diff)
        begin
            grant_next  = first_diff;
            status_next = ST_MISROUTED;
        end
        else if (found_any)
        begin
            grant_next  = last_any;
            status_next = ST_MISROUTED;
        end
        else if (in_dir == DIR_LOCAL)
        begin
            grant_next  = s1_pref_reg;
            status_next = ST_LOCAL_FALLBACK;
        end
        else
        begin
            grant_next  = '0;
            status_next = ST_NO_PORT;
        end
    end

    // Flow control
    assign in_range   = ({1'b0, s1_in_port_reg} < PORTS_LIM) &&
                        ({1'b0, s1_pref_reg} < PORTS_LIM);
    assign produces   = (s1_mode_reg == MODE_ALLOC) && in_range;
    assign out_free   = !out_valid_reg || out_ready;
    assign s1_adv     = s1_valid_reg && (!produces || out_free);
    assign in_ready   = !s1_valid_reg || s1_adv;
    assign tracker_wr = s1_adv && produces && (status_next != ST_NO_PORT);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inport_map_reg  <= MAP_RESET;
            outport_map_reg <= MAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_INPORT_MAP)
                inport_map_reg <= cfg_wdata;
            else
                outport_map_reg <= cfg_wdata;
        end
    end

    // Input stage: take a new word when empty or whenever the current one moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_mode_reg    <= mode;
            s1_in_port_reg <= in_port;
            s1_pref_reg    <= preferred_port;
        end
    end

    // Tracker valid bits: clear on tick, set on grant
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            grant_valid_reg <= '0;
        else if (s1_adv && s1_mode_reg == MODE_TICK)
            grant_valid_reg <= '0;
        else if (tracker_wr)
        begin
            for (int i = 0; i < PORTS; i++)
            begin
                if (s1_in_port_reg == PORT_W'(i))
                    grant_valid_reg[i] <= 1'b1;
            end
        end
    end

    // Tracker entries
    always_ff @(posedge clk)
    begin
        if (tracker_wr)
        begin
            for (int i = 0; i < PORTS; i++)
            begin
                if (s1_in_port_reg == PORT_W'(i))
                    grant_port_reg[i] <= grant_next;
            end
        end
    end

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg && produces;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg && produces)
        begin
            out_port_reg   <= grant_next;
            out_status_reg <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign granted_port = out_port_reg;
    assign grant_status = out_status_reg;

`ifndef NO_ASSERTIONS
    // A failed allocation reports port zero
    a_err_port_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && grant_status == ST_NO_PORT |-> granted_port == '0)
        else $error("no-port result carries a nonzero port");

    // Every grant names an existing output port
    a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {1'b0, granted_port} < PORTS_LIM)
        else $error("granted port beyond port count");

    // A tick leaves the tracker empty
    a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_mode_reg == MODE_TICK |=> grant_valid_reg == '0)
        else $error("tracker not cleared by tick");

    // A stalled result with a pending grant blocks new words
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && s1_valid_reg && produces |-> !in_ready)
        else $error("input accepted while grant path stalled");

    // The tracker never changes on a failed allocation
    a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        status_next == ST_NO_PORT && s1_mode_reg == MODE_ALLOC |-> !tracker_wr)
        else $error("tracker written on failed allocation");
`endif

endmodule
